@@ rtl/core/tss_pkg.sv @@
// Shared types and constants of the triangular substitution solver.
`default_nettype none
package tss_pkg;

	// Default and hard cap on the dimension
	localparam int DIM_DEF = 16;
	localparam int DIM_CAP = 16;

	// Datapath widths
	localparam int Q_W   = 32;
	localparam int ACC_W = 64;
	localparam int RES_W = 48;
	localparam int TOL_W = 16;
	localparam int SZ_W  = 5;

	// Residual clamp, +-(2^47-1)
	localparam logic signed [ACC_W-1:0] RES_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] RES_MIN = -64'sh0000_7FFF_FFFF_FFFF;

	// Command codes
	typedef enum logic [1:0] {
		FN_WR_MAT = 2'd0,
		FN_WR_VEC = 2'd1,
		FN_FWD    = 2'd2,
		FN_BWD    = 2'd3
	} func_t;

	// Configuration register indexes
	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_TOL  = 1'b1;

	// Multiply-accumulate controls
	typedef struct packed {
		logic clr;
		logic mul;
		logic acc;
	} mac_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/triangular_substitution_solver_top.sv @@
// Top level of the triangular substitution solver.
`default_nettype none
// Loads a triangular Q16.16 matrix and a right-hand-side vector one entry per
// beat, then on a forward or backward solve beat works row by row out of
// on-chip memories and emits one result beat per row of the effective size,
// index 0 first. Each multiply-accumulate term goes through a matrix and
// solution read, a multiply and an accumulate; each row then divides its
// residual in the bit-serial 63-step divider (start, 63 steps, done).
// A row whose pivot is skipped does not start the divider. Backward rows
// also scan their leading zeros one by one to find the pivot. No new beat
// is taken during a solve.
module triangular_substitution_solver_top #(
	parameter int MAX_DIM = tss_pkg::DIM_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire                                   cfg_addr,
	input  wire [tss_pkg::TOL_W-1:0]              cfg_wdata,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire [1:0]                             func,
	input  wire [3:0]                             row,
	input  wire [3:0]                             col,
	input  wire logic signed [tss_pkg::Q_W-1:0]   value,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [3:0]                            index,
	output logic signed [tss_pkg::Q_W-1:0]        solution,
	output logic                                  pivot_zero,
	output logic                                  last
);
	import tss_pkg::*;

	localparam int NCAP = (MAX_DIM < DIM_CAP) ? MAX_DIM : DIM_CAP;
	localparam int CW   = $clog2(NCAP + 1);
	localparam int IW   = $clog2(MAX_DIM);
	localparam int AW   = $clog2(MAX_DIM * MAX_DIM);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_ROW      = 13'b0000000000010,
		S_PIV      = 13'b0000000000100,
		S_MAC_RD   = 13'b0000000001000,
		S_MAC_MUL  = 13'b0000000010000,
		S_MAC_ACC  = 13'b0000000100000,
		S_RES      = 13'b0000001000000,
		S_DIV      = 13'b0000010000000,
		S_DIV_WAIT = 13'b0000100000000,
		S_NEXT     = 13'b0001000000000,
		S_OUT_RD   = 13'b0010000000000,
		S_OUT_LD   = 13'b0100000000000,
		S_OUT_WAIT = 13'b1000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [SZ_W-1:0]  size_q;
	logic [TOL_W-1:0] tol_q;

	// sequencer registers
	logic          bwd_q;
	logic [CW-1:0] n_q, i_q, l_q, k_q, end_q, tgt_q;
	logic signed [Q_W-1:0]   pivot_q;
	logic signed [RES_W-1:0] resid_q;
	logic                    pivok_q;
	logic [MAX_DIM-1:0]      zflag_q;
	logic [MAX_DIM-1:0]      svld_q;

	// memories
	logic signed [Q_W-1:0] mat_mem [MAX_DIM*MAX_DIM];
	logic signed [Q_W-1:0] vec_mem [MAX_DIM];
	logic signed [Q_W-1:0] sol_mem [MAX_DIM];
	logic signed [Q_W-1:0] mat_rd_q, vec_rd_q, sol_rd_q;
	logic                  sol_ok_q;

	logic          acc_beat;
	func_t         fn;
	logic [CW-1:0] n_eff;
	logic [AW-1:0] mat_ra;
	logic [IW-1:0] sol_ra;
	logic          vec_re;
	logic [CW-1:0] mat_c;

	mac_ctl_t               mac_ctl;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] res_full;
	logic signed [Q_W-1:0]   mac_b;
	logic [Q_W:0]            piv_abs;
	logic                    div_start, div_done;
	logic signed [Q_W-1:0]   div_quo;
	logic [31:0]             k_ext;

	assign in_ready = (state_q == S_IDLE);
	assign acc_beat = in_valid && in_ready;
	assign fn       = func_t'(func);

	// effective size: zero acts as one, capped
	always_comb begin
		if (size_q == '0) n_eff = CW'(1);
		else if (32'(size_q) > NCAP) n_eff = CW'(NCAP);
		else n_eff = CW'(size_q);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SZ_W'(DIM_DEF);
			tol_q  <= TOL_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SIZE: size_q <= cfg_wdata[SZ_W-1:0];
				REG_TOL:  tol_q  <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	// matrix read address by state
	always_comb begin
		case (state_q)
			S_ROW:   mat_c = i_q;
			S_PIV:   mat_c = l_q + CW'(1);
			default: mat_c = k_q;
		endcase
		mat_ra = AW'(32'(i_q) * MAX_DIM + 32'(mat_c));
		sol_ra = (state_q == S_OUT_RD) ? IW'(k_q) : IW'(k_q);
		vec_re = (state_q == S_ROW);
	end

	// matrix and vector memories
	always_ff @(posedge clk) begin
		if (acc_beat && fn == FN_WR_MAT && 32'(row) < MAX_DIM && 32'(col) < MAX_DIM) begin
			mat_mem[AW'(32'(row) * MAX_DIM + 32'(col))] <= value;
		end
		mat_rd_q <= mat_mem[mat_ra];
		if (acc_beat && fn == FN_WR_VEC && 32'(row) < MAX_DIM) begin
			vec_mem[IW'(row)] <= value;
		end
		if (vec_re) begin
			vec_rd_q <= vec_mem[IW'(i_q)];
		end
	end

	// solution memory; entries without a valid bit read as zero
	always_ff @(posedge clk) begin
		if (div_done) begin
			sol_mem[IW'(tgt_q)] <= div_quo;
		end
		sol_rd_q <= sol_mem[sol_ra];
		sol_ok_q <= svld_q[sol_ra];
	end

	assign mac_b = sol_ok_q ? sol_rd_q : '0;

	always_comb begin
		mac_ctl.clr = (state_q == S_ROW);
		mac_ctl.mul = (state_q == S_MAC_MUL);
		mac_ctl.acc = (state_q == S_MAC_ACC);
	end

	tss_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mat_rd_q),
		.b   (mac_b),
		.acc (acc)
	);

	assign res_full  = ACC_W'(vec_rd_q) - acc;
	assign piv_abs   = pivot_q[Q_W-1] ? (Q_W+1)'(-(Q_W+1)'(pivot_q)) : (Q_W+1)'(pivot_q);
	assign div_start = (state_q == S_DIV) && pivok_q;

	tss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.resid  (resid_q),
		.pivot  (pivot_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign k_ext = 32'(k_q);

	// solve sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			zflag_q   <= '0;
			svld_q    <= '0;
			out_valid <= 1'b0;
			bwd_q     <= 1'b0;
			n_q       <= '0;
			i_q       <= '0;
			l_q       <= '0;
			k_q       <= '0;
			end_q     <= '0;
			tgt_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc_beat && (fn == FN_FWD || fn == FN_BWD)) begin
						n_q     <= n_eff;
						bwd_q   <= (fn == FN_BWD);
						i_q     <= (fn == FN_BWD) ? n_eff - CW'(1) : '0;
						zflag_q <= '0;
						svld_q  <= '0;
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					l_q     <= i_q;
					state_q <= S_PIV;
				end
				S_PIV: begin
					if (!bwd_q) begin
						tgt_q   <= i_q;
						k_q     <= '0;
						end_q   <= i_q;
						state_q <= S_MAC_RD;
					end else if (mat_rd_q != '0) begin
						tgt_q   <= l_q;
						k_q     <= l_q + CW'(1);
						end_q   <= n_q;
						state_q <= S_MAC_RD;
					end else if (l_q + CW'(1) == n_q) begin
						zflag_q[IW'(i_q)] <= 1'b1;
						state_q <= S_NEXT;
					end else begin
						l_q <= l_q + CW'(1);
					end
				end
				S_MAC_RD: begin
					state_q <= (k_q == end_q) ? S_RES : S_MAC_MUL;
				end
				S_MAC_MUL: state_q <= S_MAC_ACC;
				S_MAC_ACC: begin
					k_q     <= k_q + CW'(1);
					state_q <= S_MAC_RD;
				end
				S_RES:  state_q <= S_DIV;
				S_DIV: begin
					if (pivok_q) begin
						state_q <= S_DIV_WAIT;
					end else begin
						zflag_q[IW'(tgt_q)] <= 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						svld_q[IW'(tgt_q)]  <= 1'b1;
						zflag_q[IW'(tgt_q)] <= 1'b0;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if ((!bwd_q && i_q + CW'(1) == n_q) || (bwd_q && i_q == '0)) begin
						k_q     <= '0;
						state_q <= S_OUT_RD;
					end else begin
						i_q     <= bwd_q ? i_q - CW'(1) : i_q + CW'(1);
						state_q <= S_ROW;
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: begin
					out_valid <= 1'b1;
					state_q   <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (last) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pivot capture, pivot test and clamped residual
	always_ff @(posedge clk) begin
		if (state_q == S_PIV) begin
			pivot_q <= mat_rd_q;
		end
		if (state_q == S_RES) begin
			pivok_q <= (pivot_q != '0) &&
				(!(bwd_q || i_q == '0) || piv_abs >= (Q_W+1)'(tol_q));
			if (res_full > RES_MAX) resid_q <= RES_W'(RES_MAX);
			else if (res_full < RES_MIN) resid_q <= RES_W'(RES_MIN);
			else resid_q <= RES_W'(res_full);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_OUT_LD) begin
			index      <= k_ext[3:0];
			solution   <= sol_ok_q ? sol_rd_q : '0;
			pivot_zero <= zflag_q[IW'(k_q)];
			last       <= (k_q + CW'(1) == n_q);
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/tss_mac.sv @@
// Multiply-accumulate unit: exact product, floor to Q16.16, 64-bit sum.
`default_nettype none
module tss_mac (
	input  wire                               clk,
	input  tss_pkg::mac_ctl_t                 ctl,
	input  wire logic signed [tss_pkg::Q_W-1:0]   a,
	input  wire logic signed [tss_pkg::Q_W-1:0]   b,
	output logic signed [tss_pkg::ACC_W-1:0]      acc
);
	import tss_pkg::*;

	logic signed [ACC_W-1:0] prod_s1;
	logic signed [ACC_W-1:0] acc_q;

	// product register, then arithmetic shift (floor) into the sum
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= ACC_W'(a) * ACC_W'(b);
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			acc_q <= acc_q + (prod_s1 >>> 16);
		end
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

@@ rtl/core/tss_div.sv @@
// Bit-serial signed divider: residual * 2^16 / pivot, truncated, saturated.
`default_nettype none
module tss_div (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire logic signed [tss_pkg::RES_W-1:0] resid,
	input  wire logic signed [tss_pkg::Q_W-1:0]   pivot,
	output logic                                  done,
	output logic signed [tss_pkg::Q_W-1:0]        quo
);
	import tss_pkg::*;

	localparam int DV_W = RES_W + 15;	// magnitude of resid << 16

	logic [Q_W:0]       rem_q;
	logic [DV_W-1:0]    quo_q;
	logic [Q_W-1:0]     dvs_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic               fin_q;
	logic [RES_W-1:0]   res_abs;
	logic [Q_W:0]       shv;
	logic [Q_W:0]       dvs_ext;

	assign res_abs = resid[RES_W-1] ? RES_W'(-resid) : RES_W'(resid);
	assign shv     = {rem_q[Q_W-1:0], quo_q[DV_W-1]};
	assign dvs_ext = {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= {res_abs[RES_W-2:0], 16'b0};
			dvs_q <= Q_W'(pivot[Q_W-1] ? -pivot : pivot);
			neg_q <= resid[RES_W-1] ^ pivot[Q_W-1];
		end else if (busy_q) begin
			if (shv >= dvs_ext) begin
				rem_q <= shv - dvs_ext;
				quo_q <= {quo_q[DV_W-2:0], 1'b1};
			end else begin
				rem_q <= shv;
				quo_q <= {quo_q[DV_W-2:0], 1'b0};
			end
		end
	end

	// sign and saturation
	always_comb begin
		if (!neg_q) begin
			if (quo_q > DV_W'(32'h7FFF_FFFF)) quo = 32'sh7FFF_FFFF;
			else quo = Q_W'(quo_q[Q_W-1:0]);
		end else begin
			if (quo_q > DV_W'(32'h8000_0000)) quo = 32'sh8000_0000;
			else quo = Q_W'(-quo_q[Q_W-1:0]);
		end
	end

	assign done = fin_q;
endmodule
`default_nettype wire

@@ sim/tb_triangular_substitution_solver_top.sv @@
// Testbench for the triangular substitution solver: directed table plus random solves.
`timescale 1ns / 100ps
module tb_triangular_substitution_solver_top;
	import tss_pkg::*;

	localparam int  RAND_ITEMS = 410;
	localparam int  QUIET_TAIL = 60;
	localparam int  DRAIN_CYC  = 12;
	localparam int  LIMIT_CYC  = 800000;
	localparam int  LONG_HOLD  = 2000;

	localparam logic [15:0] PHASE_SIZE [6] = '{16'd4, 16'd2, 16'd16, 16'd3, 16'd8, 16'd31};
	localparam logic [15:0] PHASE_TOL  [6] = '{16'd1, 16'd0, 16'd1, 16'd65535, 16'd300, 16'd0};

	typedef struct {
		logic [3:0]         index;
		logic signed [31:0] solution;
		logic               pivot_zero;
		logic               last;
	} sol_beat_t;

	typedef enum logic { ROW_CFG, ROW_BEAT } row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic               reg_idx;
		logic [15:0]        reg_val;
		func_t              fn;
		logic [3:0]         r;
		logic [3:0]         c;
		logic signed [31:0] v;
		bit                 typed;
		logic signed [31:0] xsol;
		bit                 xzero;
	} dir_row_t;

	// DUT ports
	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic               cfg_addr = 0;
	logic [15:0]        cfg_wdata = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         func = 0;
	logic [3:0]         row = 0;
	logic [3:0]         col = 0;
	logic signed [31:0] value = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [3:0]         index;
	logic signed [31:0] solution;
	logic               pivot_zero;
	logic               last;

	// Predictor state
	logic signed [31:0] mat_q [256];
	logic signed [31:0] vec_q [16];
	bit                 mat_seen [256];
	bit                 vec_seen [16];
	logic [4:0]         size_q = 5'd16;
	logic [15:0]        tol_q = 16'd1;
	sol_beat_t          sol_expect [$];

	// Run bookkeeping
	int  sent = 0;
	int  solves = 0;
	int  checked = 0;
	int  mismatches = 0;
	int  cycles = 0;
	bit  quiet = 0;
	bit  hold_req = 0;
	int  hold_left = 0;
	int  stall_left = 0;
	dir_row_t dir_tab [$];

	triangular_substitution_solver_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .row(row), .col(col), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.index(index), .solution(solution), .pivot_zero(pivot_zero), .last(last)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYC) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				sol_expect.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int dim_in_use();
		int n;
		n = size_q;
		if (n == 0) n = 1;
		if (n > 16) n = 16;
		return n;
	endfunction

	function automatic bit pivot_passes(logic signed [31:0] p);
		longint m;
		m = longint'(p);
		if (m < 0) m = -m;
		return (p != 0) && (m >= longint'(tol_q));
	endfunction

	// Residual clamp, truncating divide, saturate to 32 bits
	function automatic logic signed [31:0] fix_div(longint resid, logic signed [31:0] piv);
		longint q;
		if (resid > 64'sh0000_7FFF_FFFF_FFFF) resid = 64'sh0000_7FFF_FFFF_FFFF;
		if (resid < -64'sh0000_7FFF_FFFF_FFFF) resid = -64'sh0000_7FFF_FFFF_FFFF;
		q = (resid * 65536) / longint'(piv);
		if (q > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (q < -64'sh8000_0000) return 32'sh8000_0000;
		return q[31:0];
	endfunction

	function automatic longint mac_term(logic signed [31:0] a, logic signed [31:0] b);
		return (longint'(a) * longint'(b)) >>> 16;
	endfunction

	// Substitution over the modeled stores, results queued index 0 first
	function automatic void predict_solve(func_t fn);
		logic signed [31:0] x [16];
		bit                 zf [16];
		int                 n, i, k, l;
		longint             acc;
		logic signed [31:0] piv;
		sol_beat_t          b;
		n = dim_in_use();
		for (i = 0; i < 16; i++) begin
			x[i] = 0;
			zf[i] = 0;
		end
		if (fn == FN_FWD) begin
			for (i = 0; i < n; i++) begin
				acc = 0;
				for (k = 0; k < i; k++) acc += mac_term(mat_q[i*16+k], x[k]);
				piv = mat_q[i*16+i];
				if ((i == 0) ? pivot_passes(piv) : (piv != 0)) begin
					x[i] = fix_div(longint'(vec_q[i]) - acc, piv);
					zf[i] = 0;
				end else begin
					zf[i] = 1;
				end
			end
		end else begin
			piv = mat_q[(n-1)*16+n-1];
			if (pivot_passes(piv)) x[n-1] = fix_div(longint'(vec_q[n-1]), piv);
			else zf[n-1] = 1;
			for (i = n - 2; i >= 0; i--) begin
				acc = 0;
				l = i;
				while (l < n && mat_q[i*16+l] == 0) l++;
				if (l >= n) begin
					zf[i] = 1;
				end else begin
					for (k = l + 1; k < n; k++) acc += mac_term(mat_q[i*16+k], x[k]);
					piv = mat_q[i*16+l];
					if (pivot_passes(piv)) begin
						x[l] = fix_div(longint'(vec_q[i]) - acc, piv);
						zf[l] = 0;
					end else begin
						zf[l] = 1;
					end
				end
			end
		end
		for (i = 0; i < n; i++) begin
			b.index = i[3:0];
			b.solution = x[i];
			b.pivot_zero = zf[i];
			b.last = (i == n - 1);
			sol_expect.push_back(b);
		end
	endfunction

	// Offer one beat, with an optional idle burst first
	task automatic put_beat(func_t fn, logic [3:0] r, logic [3:0] c, logic signed [31:0] v,
			bit typed = 0, logic signed [31:0] xsol = 0, bit xzero = 0);
		int gap;
		sol_beat_t b;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		row <= r;
		col <= c;
		value <= v;
		do @(posedge clk); while (!in_ready);
		sent++;
		case (fn)
			FN_WR_MAT: begin
				mat_q[{r, c}] = v;
				mat_seen[{r, c}] = 1;
			end
			FN_WR_VEC: begin
				vec_q[r] = v;
				vec_seen[r] = 1;
			end
			default: begin
				solves++;
				if (typed) begin
					b.index = 0;
					b.solution = xsol;
					b.pivot_zero = xzero;
					b.last = 1;
					sol_expect.push_back(b);
				end else begin
					predict_solve(fn);
				end
			end
		endcase
	endtask

	// Register write once the block has gone idle
	task automatic set_reg(logic idx, logic [15:0] d);
		in_valid <= 1'b0;
		while (sol_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SIZE) size_q = d[4:0];
		else tol_q = d;
	endtask

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			3: return $urandom();
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_pivot();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(1, 300);
			2: return -$signed($urandom_range(1, 70000));
			default: return $signed($urandom_range(16'h4000, 32'h0004_0000));
		endcase
	endfunction

	// One triangular system with random content, mostly well formed
	task automatic run_system();
		int    n, i, j;
		func_t fn;
		bit    upper;
		bit    need;
		n = dim_in_use();
		upper = $urandom_range(0, 1);
		// a broken sequence now and then solves the other way
		if ($urandom_range(0, 9) == 0) fn = upper ? FN_FWD : FN_BWD;
		else fn = upper ? FN_BWD : FN_FWD;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				if ((upper ? j >= i : j <= i) && $urandom_range(0, 2) != 0)
					put_beat(FN_WR_MAT, 4'(i), 4'(j), (i == j) ? rand_pivot() : rand_q());
			end
			if ($urandom_range(0, 3) != 0)
				put_beat(FN_WR_VEC, 4'(i), 4'($urandom()), rand_q());
			if ($urandom_range(0, 7) == 0)
				put_beat(func_t'($urandom_range(0, 1)), 4'($urandom()), 4'($urandom()),
					rand_q());
		end
		// never let a solve read an unwritten entry
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				need = (fn == FN_BWD) ? (j >= i) : (j <= i);
				if (need && !mat_seen[i*16+j])
					put_beat(FN_WR_MAT, 4'(i), 4'(j), (i == j) ? 32'sh0 : rand_q());
			end
			if (!vec_seen[i]) put_beat(FN_WR_VEC, 4'(i), 4'($urandom()), rand_q());
		end
		put_beat(fn, 4'($urandom()), 4'($urandom()), $urandom());
	endtask

	function automatic dir_row_t cfg_row(logic idx, logic [15:0] d);
		dir_row_t t;
		t.kind = ROW_CFG;
		t.reg_idx = idx;
		t.reg_val = d;
		t.fn = FN_WR_MAT;
		t.r = 0;
		t.c = 0;
		t.v = 0;
		t.typed = 0;
		t.xsol = 0;
		t.xzero = 0;
		return t;
	endfunction

	function automatic dir_row_t beat_row(func_t fn, logic [3:0] r, logic [3:0] c,
			logic signed [31:0] v, bit typed = 0, logic signed [31:0] xsol = 0, bit xzero = 0);
		dir_row_t t;
		t.kind = ROW_BEAT;
		t.reg_idx = 0;
		t.reg_val = 0;
		t.fn = fn;
		t.r = r;
		t.c = c;
		t.v = v;
		t.typed = typed;
		t.xsol = xsol;
		t.xzero = xzero;
		return t;
	endfunction

	// Result checker and receiver stall pattern
	always @(posedge clk) begin
		sol_beat_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				checked++;
				if (sol_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: index %0d solution %h", index, solution);
				end else begin
					e = sol_expect.pop_front();
					if (index !== e.index || solution !== e.solution ||
							pivot_zero !== e.pivot_zero || last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Mismatch: exp idx %0d sol %h pz %0b last %0b,",
								" got idx %0d sol %h pz %0b last %0b"},
								e.index, e.solution, e.pivot_zero, e.last,
								index, solution, pivot_zero, last);
					end
				end
			end
			if (hold_req) begin
				hold_req = 0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Main sequence
	initial begin
		int p, goal, base;
		dir_row_t t;

		// Directed: size one extremes, saturation, zero and tolerance pivots
		dir_tab.push_back(cfg_row(REG_SIZE, 16'd1));
		dir_tab.push_back(beat_row(FN_WR_MAT, 0, 0, 32'sh0001_0000));
		dir_tab.push_back(beat_row(FN_WR_VEC, 0, 0, 32'sh7FFF_FFFF));
		dir_tab.push_back(beat_row(FN_FWD, 0, 0, 0, 1, 32'sh7FFF_FFFF, 0));
		dir_tab.push_back(beat_row(FN_WR_MAT, 0, 0, 32'sh0000_0001));
		dir_tab.push_back(beat_row(FN_BWD, 15, 15, -1, 1, 32'sh7FFF_FFFF, 0));
		dir_tab.push_back(beat_row(FN_WR_VEC, 0, 15, 32'sh8000_0000));
		dir_tab.push_back(beat_row(FN_FWD, 0, 0, 0, 1, 32'sh8000_0000, 0));
		dir_tab.push_back(beat_row(FN_WR_MAT, 0, 0, 0));
		dir_tab.push_back(beat_row(FN_FWD, 0, 0, 0, 1, 0, 1));
		dir_tab.push_back(beat_row(FN_BWD, 0, 0, 0, 1, 0, 1));
		dir_tab.push_back(beat_row(FN_WR_MAT, 0, 0, 32'sh8000_0000));
		dir_tab.push_back(beat_row(FN_BWD, 0, 0, 0, 1, 32'sh0001_0000, 0));
		dir_tab.push_back(cfg_row(REG_TOL, 16'hFFFF));
		dir_tab.push_back(beat_row(FN_WR_MAT, 0, 0, 32'shFFFF_8000));
		dir_tab.push_back(beat_row(FN_FWD, 0, 0, 0, 1, 0, 1));
		dir_tab.push_back(beat_row(FN_WR_MAT, 0, 0, 32'shFFFF_0001));
		dir_tab.push_back(beat_row(FN_BWD, 0, 0, 0, 1, 32'sh7FFF_FFFF, 0));
		dir_tab.push_back(cfg_row(REG_SIZE, 16'd0));
		dir_tab.push_back(beat_row(FN_WR_MAT, 0, 0, 32'sh0002_0000));
		dir_tab.push_back(beat_row(FN_FWD, 0, 0, 0, 1, 32'shC000_0000, 0));
		dir_tab.push_back(beat_row(FN_WR_MAT, 15, 15, 32'sh7FFF_FFFF));
		dir_tab.push_back(beat_row(FN_WR_VEC, 15, 0, 32'shFFFF_FFFF));
		dir_tab.push_back(beat_row(FN_WR_MAT, 15, 0, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[di]) begin
			t = dir_tab[di];
			if (t.kind == ROW_CFG) set_reg(t.reg_idx, t.reg_val);
			else put_beat(t.fn, t.r, t.c, t.v, t.typed, t.xsol, t.xzero);
		end
		base = sent;

		// Random systems over several size and tolerance settings
		for (p = 0; p < 6; p++) begin
			set_reg(REG_SIZE, PHASE_SIZE[p]);
			set_reg(REG_TOL, PHASE_TOL[p]);
			goal = base + (p + 1) * RAND_ITEMS / 6;
			// long receiver hold over a solve while the next system is offered
			if (p == 4) begin
				run_system();
				hold_req = 1;
			end
			do begin
				if (sent > base + RAND_ITEMS - QUIET_TAIL) quiet = 1;
				run_system();
			end while (sent < goal);
		end
		in_valid <= 1'b0;

		while (sol_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC * 4) @(posedge clk);

		$display("Sent %0d beats including %0d solves over sizes 0 to 31 and tolerances 0 to 65535,",
			sent, solves);
		$display("checked %0d result beats, %0d mismatches", checked, mismatches);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
